// ===== hw/rtl/cwps_pkg.sv =====
// ----------------------------------------------------------------------------
// cwps_pkg
// Shared constants and types for the cache way partition search block.
// ----------------------------------------------------------------------------
`default_nettype none

package cwps_pkg;

    localparam int CWPS_MAX_CPUS = 4;
    localparam int CWPS_MAX_WAYS = 16;

    localparam int CPU_COUNT_W = 3;
    localparam int WAY_COUNT_W = 5;
    localparam int CFG_DATA_W  = 5;
    localparam int SCORE_W     = 34;
    localparam int HIT_W       = 32;

    localparam logic [CPU_COUNT_W-1:0] CPU_COUNT_RST = 3'd4;
    localparam logic [WAY_COUNT_W-1:0] WAY_COUNT_RST = 5'd16;

    typedef enum logic {
        CFG_CPU_COUNT = 1'b0,
        CFG_WAY_COUNT = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        MODE_LOAD   = 1'b0,
        MODE_SEARCH = 1'b1
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_PREP,
        S_READ,
        S_DRAIN,
        S_CMP,
        S_NEXT,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/cache_way_partition_search_top.sv =====
// ----------------------------------------------------------------------------
// cache_way_partition_search_top
// Loads are accepted back to back, one per cycle, while the block is idle.
// A search first works out the default split w/n, then steps through each prefix
// of the enumeration and, for each allocation that fits, reads the hit table once
// per cpu through the single read port, then gives n results, one per cpu.
// Reset clears control state and sets cpu_count to 4 and way_count to 16;
// the hit table is not cleared and must be loaded before it is searched.
// ----------------------------------------------------------------------------
`default_nettype none

module cache_way_partition_search_top #(
    parameter int MAX_CPUS = cwps_pkg::CWPS_MAX_CPUS,
    parameter int MAX_WAYS = cwps_pkg::CWPS_MAX_WAYS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire cwps_pkg::t_cfg_idx            i_cfg_idx,
    input  wire logic [cwps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                          i_req_valid,
    output logic                               o_req_ready,
    input  wire logic                          i_mode,
    input  wire logic [1:0]                    i_cpu_index,
    input  wire logic [3:0]                    i_way_index,
    input  wire logic [cwps_pkg::HIT_W-1:0]    i_hit_count,
    output logic                               o_res_valid,
    input  wire logic                          i_res_ready,
    output logic [1:0]                         o_cpu_id,
    output logic [4:0]                         o_ways_given,
    output logic [cwps_pkg::SCORE_W-1:0]       o_best_score,
    output logic                               o_last
);

    import cwps_pkg::*;

    localparam int CPU_W  = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
    localparam int CNT_W  = $clog2(MAX_CPUS + 1);
    localparam int WAY_W  = $clog2(MAX_WAYS + 1);
    localparam int IDX_W  = $clog2(MAX_WAYS);
    localparam int ADDR_W = CPU_W + IDX_W;
    localparam int DEPTH  = MAX_CPUS << IDX_W;
    localparam int PRE_W  = $clog2(MAX_CPUS * MAX_WAYS + 1);

    // configuration
    logic [CPU_COUNT_W-1:0] r_cpu_count;
    logic [WAY_COUNT_W-1:0] r_way_count;

    // control
    t_state             r_state;
    t_state             n_state;
    logic [CPU_W-1:0]   r_c;
    logic [CPU_W-1:0]   r_oc;
    logic               r_rd_vld;

    // datapath
    logic [HIT_W-1:0]   r_mem [DEPTH];
    logic [HIT_W-1:0]   r_rdata;
    logic [WAY_W-1:0]   r_trial [MAX_CPUS];
    logic [WAY_W-1:0]   n_trial [MAX_CPUS];
    logic [WAY_W-1:0]   r_best_ways [MAX_CPUS];
    logic [SCORE_W-1:0] r_acc;
    logic [SCORE_W-1:0] r_best;
    logic [WAY_W-1:0]   r_rem;
    logic [WAY_W-1:0]   r_q;

    logic [CNT_W-1:0]   n_act;
    logic [WAY_W-1:0]   w_act;
    logic [WAY_W-1:0]   w_max;
    logic [CPU_W-1:0]   last_cpu;
    logic [PRE_W-1:0]   pre;
    logic               pre_fits;
    logic [WAY_W-1:0]   rest;
    logic               odo_found;
    logic [CPU_W-1:0]   odo_pos;
    logic               div_more;
    logic               rd_last;
    logic               out_last;
    logic               req_acc;
    logic               res_acc;
    logic               load_ok;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;

    // saturated register values
    always_comb begin
        if (r_cpu_count == '0) begin
            n_act = CNT_W'(1);
        end else if (32'(r_cpu_count) > MAX_CPUS) begin
            n_act = CNT_W'(MAX_CPUS);
        end else begin
            n_act = CNT_W'(r_cpu_count);
        end
        if (r_way_count < 5'd2) begin
            w_act = WAY_W'(2);
        end else if (32'(r_way_count) > MAX_WAYS) begin
            w_act = WAY_W'(MAX_WAYS);
        end else begin
            w_act = WAY_W'(r_way_count);
        end
    end

    assign w_max    = w_act - WAY_W'(1);
    assign last_cpu = CPU_W'(n_act - CNT_W'(1));
    assign rd_last  = (r_c == last_cpu);
    assign out_last = (r_oc == last_cpu);
    assign div_more = (r_rem >= WAY_W'(n_act));

    // prefix sum and the one last-cpu share that can fit
    always_comb begin
        pre = '0;
        for (int i = 0; i < MAX_CPUS; i++) begin
            if (CNT_W'(i + 1) < n_act) begin
                pre = pre + PRE_W'(r_trial[i]);
            end
        end
        pre_fits = (pre < PRE_W'(w_act));
        rest     = WAY_W'(PRE_W'(w_act) - pre);
    end

    // odometer step over the prefix, last position fastest
    always_comb begin
        odo_found = 1'b0;
        odo_pos   = '0;
        for (int i = 0; i < MAX_CPUS; i++) begin
            if (CNT_W'(i + 1) < n_act && r_trial[i] < w_max) begin
                odo_found = 1'b1;
                odo_pos   = CPU_W'(i);
            end
        end
        for (int i = 0; i < MAX_CPUS; i++) begin
            if (CPU_W'(i) == odo_pos) begin
                n_trial[i] = r_trial[i] + WAY_W'(1);
            end else if (CPU_W'(i) > odo_pos && CNT_W'(i + 1) < n_act) begin
                n_trial[i] = WAY_W'(1);
            end else begin
                n_trial[i] = r_trial[i];
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (req_acc && i_mode == MODE_SEARCH) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (!div_more) begin
                    n_state = (n_act == CNT_W'(1)) ? S_OUT : S_PREP;
                end
            end
            S_PREP:  n_state = pre_fits ? S_READ : S_NEXT;
            S_READ: begin
                if (rd_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_CMP;
            S_CMP:   n_state = S_NEXT;
            S_NEXT:  n_state = odo_found ? S_PREP : S_OUT;
            S_OUT: begin
                if (res_acc && out_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        unique case (r_state)
            S_IDLE:  o_req_ready = 1'b1;
            S_OUT:   o_res_valid = 1'b1;
            default: begin
                o_req_ready = 1'b0;
                o_res_valid = 1'b0;
            end
        endcase
    end

    assign req_acc = i_req_valid && o_req_ready;
    assign res_acc = o_res_valid && i_res_ready;
    assign load_ok = (32'(i_cpu_index) < MAX_CPUS) && (32'(i_way_index) < MAX_WAYS);
    assign wr_addr = ADDR_W'((32'(i_cpu_index) << IDX_W) | 32'(i_way_index));
    assign rd_addr = {r_c, r_trial[r_c][IDX_W-1:0]};

    assign o_cpu_id     = 2'(r_oc);
    assign o_ways_given = 5'(r_best_ways[r_oc]);
    assign o_best_score = r_best;
    assign o_last       = out_last;

    // hit table
    always_ff @(posedge i_clk) begin
        if (req_acc && i_mode == MODE_LOAD && load_ok) begin
            r_mem[wr_addr] <= i_hit_count;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cpu_count <= CPU_COUNT_RST;
            r_way_count <= WAY_COUNT_RST;
            r_rd_vld    <= 1'b0;
            r_c         <= '0;
            r_oc        <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == S_READ);
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_CPU_COUNT: r_cpu_count <= i_cfg_data[CPU_COUNT_W-1:0];
                    CFG_WAY_COUNT: r_way_count <= i_cfg_data[WAY_COUNT_W-1:0];
                endcase
            end
            if (r_state == S_PREP) begin
                r_c <= '0;
            end else if (r_state == S_READ && !rd_last) begin
                r_c <= r_c + CPU_W'(1);
            end
            if (r_state == S_IDLE) begin
                r_oc <= '0;
            end else if (res_acc) begin
                r_oc <= r_oc + CPU_W'(1);
            end
        end
    end

    // search datapath
    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_acc <= r_acc + SCORE_W'(r_rdata);
        end
        unique case (r_state)
            S_IDLE: begin
                if (req_acc && i_mode == MODE_SEARCH) begin
                    r_best <= '0;
                    r_rem  <= w_act;
                    r_q    <= '0;
                    for (int i = 0; i < MAX_CPUS; i++) begin
                        r_trial[i] <= WAY_W'(1);
                    end
                end
            end
            S_DIV: begin
                if (div_more) begin
                    r_rem <= r_rem - WAY_W'(n_act);
                    r_q   <= r_q + WAY_W'(1);
                end else begin
                    for (int i = 0; i < MAX_CPUS; i++) begin
                        r_best_ways[i] <= (CNT_W'(i) < n_act) ? r_q : '0;
                    end
                end
            end
            S_PREP: begin
                r_acc <= '0;
                if (pre_fits) begin
                    r_trial[last_cpu] <= rest;
                end
            end
            S_CMP: begin
                if (r_acc > r_best) begin
                    r_best <= r_acc;
                    for (int i = 0; i < MAX_CPUS; i++) begin
                        if (CNT_W'(i) < n_act) begin
                            r_best_ways[i] <= r_trial[i];
                        end
                    end
                end
            end
            S_NEXT: begin
                if (odo_found) begin
                    for (int i = 0; i < MAX_CPUS; i++) begin
                        r_trial[i] <= n_trial[i];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // checks
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_req_ready && o_res_valid))
        else $error("request and result sides open together");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_trial[r_c] != '0 && r_trial[r_c] < w_act))
        else $error("hit table read outside the allocation range");

    a_back_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_acc && o_last) |=> o_req_ready)
        else $error("block not idle after the final result");

    a_best_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CMP && r_state != S_IDLE) |=> $stable(r_best))
        else $error("best score changed outside compare");

endmodule

`default_nettype wire
